@@ design/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the stable insertion sort by frequency.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int CAPACITY  = 64;
   localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int SYM_W     = 7;
   localparam int FREQ_W    = 32;
   localparam int REC_W     = SYM_W + FREQ_W;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol_code;
      logic [FREQ_W-1:0] frequency;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]  out_symbol;
      logic [FREQ_W-1:0] out_frequency;
      logic              out_last;
      logic              overflowed;
   } rsp_type;

   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [FREQ_W-1:0] freq;
   } rec_type;

   // Source of the word written into the store.
   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_NEW   = 2'd1,
      WR_SHIFT = 2'd2
   } wr_sel_type;

   // Address of the store read.
   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_TOP  = 2'd1,
      RD_NEXT = 2'd2,
      RD_EMIT = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       drop;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      logic       pos_load;
      logic       pos_dec;
      logic       count_inc;
      logic       emit_step;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic greater;
      logic pos_one;
      logic last;
      logic emit_end;
   } stat_type;

endpackage

@@ design/stable_insertion_sort_by_frequency.sv @@
// ----------------------------------------------------------------------------
// stable_insertion_sort_by_frequency
// Stable insertion sort of symbol records, ascending by frequency.
// ----------------------------------------------------------------------------
// A record is loaded, then dropped when the store is full or written to slot
// zero when it is empty; otherwise the compare-and-shift loop over the record
// RAM moves each held record with a larger frequency up one slot, then writes
// the new one into the freed slot. A record marked last then streams n
// results, one per cycle, the first in the cycle after the sequencer enters
// its emit phase; busy drops in the cycle that carries the final result.
// Results cannot be stalled: each beat shows for exactly one cycle on rsp_valid.
// Reset (synchronous, active high) empties the store and clears the overflow
// flag; the record RAM itself is not cleared, as only filled entries are read.
// ----------------------------------------------------------------------------
module stable_insertion_sort_by_frequency
   import sfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // The controller sequences each beat; the datapath holds the sorted store,
   // the insertion pointer and the fill count, and reports compare results.
   cmd_type  cmd;
   stat_type stat;

   sfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Insertion walks down from the top of the store. Each cycle compares the
   // entry just read with the new key; a larger entry moves up one slot while
   // the next one is read, so equal keys stay ahead of the new record.
   sfs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/sfs_ram.sv @@
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer for loading, inserting and emitting records.
// ----------------------------------------------------------------------------
module sfs_ctrl
   import sfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INSERT = 5'b00010,
      ST_CMP    = 5'b00100,
      ST_PLACE  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.wr_sel = WR_NONE;
      cmd.rd_sel = RD_NONE;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            priority if (stat.full) begin
               cmd.drop = 1'b1;
               state_in = stat.last ? ST_EMIT : ST_IDLE;
            end else if (stat.empty) begin
               cmd.wr_sel    = WR_NEW;
               cmd.count_inc = 1'b1;
               state_in      = stat.last ? ST_EMIT : ST_IDLE;
            end else begin
               cmd.rd_sel   = RD_TOP;
               cmd.pos_load = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.greater) begin
               cmd.wr_sel  = WR_SHIFT;
               cmd.pos_dec = 1'b1;
               if (stat.pos_one) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.rd_sel = RD_NEXT;
               end
            end else begin
               cmd.wr_sel    = WR_NEW;
               cmd.count_inc = 1'b1;
               state_in      = stat.last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.wr_sel    = WR_NEW;
            cmd.count_inc = 1'b1;
            state_in      = stat.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.rd_sel    = RD_EMIT;
            cmd.emit_step = 1'b1;
            if (stat.emit_end) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ design/sfs_datapath.sv @@
// ----------------------------------------------------------------------------
// sfs_datapath
// Record store, insertion position, fill count and result registers.
// ----------------------------------------------------------------------------
module sfs_datapath
   import sfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   rec_type             new_rec_ff;
   logic                last_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                overflow_ff;
   logic [ADDR_W-1:0]   emit_idx_ff;
   logic                rsp_valid_ff;
   logic                rsp_last_ff;
   logic                rsp_over_ff;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   rec_type             wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [REC_W-1:0]    rd_raw;
   rec_type             rd_rec;
   logic [COUNT_W-1:0]  count_m1;

   assign rd_rec   = rec_type'(rd_raw);
   assign count_m1 = count_ff - COUNT_W'(1);

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = pos_ff;
      wr_data = new_rec_ff;
      unique case (cmd.wr_sel)
         WR_NONE:  wr_en = 1'b0;
         WR_NEW: begin
            wr_data = new_rec_ff;
            // The first record of a set goes to slot zero; the position
            // register is only loaded when the store already holds records.
            if (stat.empty) begin
               wr_addr = '0;
            end
         end
         WR_SHIFT: wr_data = rd_rec;
         default:  wr_en = 1'b0;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = emit_idx_ff;
      unique case (cmd.rd_sel)
         RD_NONE: rd_en = 1'b0;
         RD_TOP:  rd_addr = count_m1[ADDR_W-1:0];
         RD_NEXT: rd_addr = pos_ff - ADDR_W'(2);
         RD_EMIT: rd_addr = emit_idx_ff;
         default: rd_en = 1'b0;
      endcase
   end

   sfs_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_rec_ff.sym  <= req_data.symbol_code;
         new_rec_ff.freq <= req_data.frequency;
         last_ff         <= req_data.last;
      end
      if (cmd.pos_load) begin
         pos_ff <= count_ff[ADDR_W-1:0];
      end else if (cmd.pos_dec) begin
         pos_ff <= pos_ff - ADDR_W'(1);
      end
      rsp_last_ff <= stat.emit_end;
      rsp_over_ff <= overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_step;
         if (cmd.finish) begin
            count_ff    <= '0;
            overflow_ff <= 1'b0;
            emit_idx_ff <= '0;
         end else begin
            if (cmd.count_inc) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
            if (cmd.drop) begin
               overflow_ff <= 1'b1;
            end
            if (cmd.emit_step) begin
               emit_idx_ff <= emit_idx_ff + ADDR_W'(1);
            end
         end
      end
   end

   assign stat.full     = (count_ff == COUNT_W'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.greater  = (rd_rec.freq > new_rec_ff.freq);
   assign stat.pos_one  = (pos_ff == ADDR_W'(1));
   assign stat.last     = last_ff;
   assign stat.emit_end = ({{(COUNT_W-ADDR_W){1'b0}}, emit_idx_ff} == count_m1);

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.out_symbol    = rd_rec.sym;
   assign rsp_data.out_frequency = rd_rec.freq;
   assign rsp_data.out_last      = rsp_last_ff;
   assign rsp_data.overflowed    = rsp_over_ff;

endmodule
